FILE: sv/pfrl_pkg.sv
// Package for the per-flow packet rate limiter.
// Types, opcodes and controller state; no dependencies.
package pfrl_pkg;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [31:0] LIMIT_RESET = 32'd102400;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } pfrl_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic clr_step;
    logic upd;
    logic out_load;
  } pfrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_clear;
    logic is_ipv4;
  } pfrl_stat_t;

endpackage

FILE: sv/pfrl_datapath.sv
// Datapath of the rate limiter: flow table memories, lookup, LRU, count update.
// Depends on pfrl_pkg.
module pfrl_datapath import pfrl_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pfrl_cmd_t   cmd,
  output pfrl_stat_t  stat,
  input  logic        in_op,
  input  logic        in_v4,
  input  logic [31:0] in_src,
  input  logic [31:0] in_dst,
  input  logic [31:0] limit,
  output logic [97:0] res
);
  localparam int SETS0 = TABLE_ENTRIES / WAYS;
  localparam int SETS  = (SETS0 > 0) ? SETS0 : 1;
  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int VW    = WAYS * (1 + AW);

  logic [WAYS*64-1:0] key_mem [SETS];
  logic [WAYS*32-1:0] cnt_mem [SETS];
  logic [VW-1:0]      va_mem  [SETS];

  logic         op_r, v4_r;
  logic [31:0]  src_r, dst_r;
  logic [SW-1:0] set_r, clr_r;
  logic [WAYS*64-1:0] key_rd_r;
  logic [WAYS*32-1:0] cnt_rd_r;
  logic [VW-1:0]      va_rd_r;
  logic [97:0]  res_r;
  logic         clr_done_r;

  logic [31:0] hash;
  assign hash = in_src ^ in_dst ^ (in_src >> 16) ^ (in_dst >> 16);

  logic [SW-1:0] set_idx;
  always_comb begin
    if (SETS > 1) set_idx = SW'(hash % SETS);
    else          set_idx = '0;
  end

  logic [VW-1:0] va_init;
  always_comb begin
    va_init = '0;
    for (int w = 0; w < WAYS; w++) va_init[w*(1+AW) +: AW] = AW'(w);
  end

  // lookup and replacement on the registered set
  logic           hit, free_found;
  logic [WW-1:0]  way;
  logic [AW-1:0]  old_age, oldest;
  logic [31:0]    cnt_old, cnt_new;
  logic           changed;
  logic [VW-1:0]  va_new;
  logic [WAYS*64-1:0] key_wr;
  logic [WAYS*32-1:0] cnt_wr;
  logic           drop, notify;

  always_comb begin
    hit = 1'b0; free_found = 1'b0; way = '0; oldest = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (va_rd_r[w*(1+AW)+AW] && key_rd_r[w*64 +: 64] == {src_r, dst_r}) begin
        hit = 1'b1; way = WW'(w);
      end
    end
    if (!hit) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!va_rd_r[w*(1+AW)+AW]) begin
          free_found = 1'b1; way = WW'(w);
        end
      end
      if (!free_found) begin
        for (int w = 0; w < WAYS; w++) begin
          if (va_rd_r[w*(1+AW) +: AW] >= oldest) begin
            oldest = va_rd_r[w*(1+AW) +: AW]; way = WW'(w);
          end
        end
      end
    end
    cnt_old = cnt_rd_r[way*32 +: 32];
    if (hit) begin
      changed = cnt_old != COUNT_MAX;
      cnt_new = changed ? cnt_old + 32'd1 : cnt_old;
    end else begin
      changed = 1'b1;
      cnt_new = 32'd1;
    end
    old_age = va_rd_r[way*(1+AW) +: AW];
    va_new = va_rd_r;
    for (int w = 0; w < WAYS; w++) begin
      if (va_rd_r[w*(1+AW) +: AW] < old_age)
        va_new[w*(1+AW) +: AW] = va_rd_r[w*(1+AW) +: AW] + AW'(1);
    end
    va_new[way*(1+AW) +: AW] = '0;
    va_new[way*(1+AW)+AW] = 1'b1;
    key_wr = key_rd_r;
    key_wr[way*64 +: 64] = {src_r, dst_r};
    cnt_wr = cnt_rd_r;
    cnt_wr[way*32 +: 32] = cnt_new;
    drop = cnt_new > limit;
    notify = drop && changed && ({1'b0, cnt_new} == {1'b0, limit} + 33'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; v4_r <= in_v4; src_r <= in_src; dst_r <= in_dst;
      set_r <= set_idx;
    end
    if (cmd.rd) begin
      key_rd_r <= key_mem[set_r];
      cnt_rd_r <= cnt_mem[set_r];
      va_rd_r  <= va_mem[set_r];
    end
    if (cmd.clr_step) va_mem[clr_r] <= va_init;
    else if (cmd.upd) begin
      va_mem[set_r]  <= va_new;
      key_mem[set_r] <= key_wr;
      cnt_mem[set_r] <= cnt_wr;
    end
    if (cmd.out_load) begin
      if (op_r == OP_CLEAR || !v4_r) res_r <= '0;
      else res_r <= {notify ? dst_r : 32'd0, notify ? src_r : 32'd0,
                     cnt_new, notify, drop};
    end
  end

  // clear sweep counter; also runs once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_done_r <= 1'b0;
    end else if (cmd.load) begin
      clr_r <= '0; clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_done_r <= (clr_r == SW'(SETS - 1));
      clr_r <= clr_r + SW'(1);
    end
  end

  assign stat.clr_done = clr_done_r;
  assign stat.is_clear = op_r == OP_CLEAR;
  assign stat.is_ipv4  = v4_r;
  assign res = res_r;
endmodule

FILE: sv/pfrl_ctrl.sv
// Controller of the rate limiter: sequences clear sweep, read, update, output.
// Depends on pfrl_pkg.
module pfrl_ctrl import pfrl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_busy,
  input  pfrl_stat_t stat,
  output pfrl_cmd_t  cmd,
  output logic       in_ready,
  output logic       res_valid
);
  pfrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_READ;
      ST_CLEAR:  if (stat.clr_done) state_nxt = ST_IDLE;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT:    if (!out_busy) state_nxt = stat.is_clear ? ST_CLEAR : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_fire; end
      ST_CLEAR:  cmd.clr_step = !stat.clr_done;
      ST_READ:   cmd.rd = 1'b1;
      ST_UPDATE: cmd.upd = !stat.is_clear && stat.is_ipv4;
      ST_OUT:    begin
        cmd.out_load = !out_busy;
        res_valid = !out_busy;
      end
      default:   ;
    endcase
  end
endmodule

FILE: sv/per_flow_packet_rate_limiter_top.sv
// Channel     Dir  Fields
// in_         in   tdata: operation, is_ipv4, source_address, dest_address
// out_        out  tdata: drop, notify, flow_count, event_source, event_dest
// cfg_        in   packet_limit
// Each item passes accept, set read, update and result in turn; no new item is taken until then; set memory port bound.
// After reset and after a clear command the table sweeps all SETS sets, no input taken.
// Output register holds the result; the next result waits until it is taken.
module per_flow_packet_rate_limiter_top import pfrl_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int WAYS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,  // operation, is_ipv4, source_address, dest_address
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata, // drop, notify, flow_count, event_source, event_dest
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  pfrl_cmd_t  cmd;
  pfrl_stat_t stat;
  logic [31:0] limit_r;
  logic [97:0] res;
  logic        res_valid, out_valid_r, in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  pfrl_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r && !out_tready),
    .stat, .cmd, .in_ready(in_tready), .res_valid
  );

  pfrl_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .WAYS(WAYS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_op(in_tdata[0]), .in_v4(in_tdata[1]),
    .in_src(in_tdata[33:2]), .in_dst(in_tdata[65:34]),
    .limit(limit_r), .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_valid) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !res_valid) else $error("result overwritten");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("accepted while busy");
  a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[97:34] == 64'd0) else $error("event leak");
endmodule
